[design/byte_ring_fifo_core_assert.svh]
// ---------------------------------------------------------------------------
// byte_ring_fifo_core_assert.svh
// Assertion macros for the byte ring FIFO. They use clk and rst_n of the
// module that includes this file.
// ---------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_CORE_ASSERT_SVH
`define BYTE_RING_FIFO_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRF_CHECK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte_ring_fifo_core: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BRF_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte_ring_fifo_core: next-cycle check failed");

`endif

[design/brf_pkg.sv]
// ---------------------------------------------------------------------------
// brf_pkg
// Request and status codes, fixed widths and the control word that rides
// along with the bank read for the byte ring FIFO.
// ---------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

    // Byte banks: one per byte of a word, indexed by the low address bits
    localparam int BANKS  = 8;
    localparam int BANK_W = 3;

    localparam int DATA_W  = 64;
    localparam int COUNT_W = 4;
    localparam int LEVEL_W = 12;

    // Request codes
    localparam logic [1:0] REQ_ENQ  = 2'd0;
    localparam logic [1:0] REQ_DEQ  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;
    localparam logic [1:0] REQ_DISC = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ROOM = 2'd1;
    localparam logic [1:0] ST_NO_DATA = 2'd2;

    // Control word held beside the bank read data
    typedef struct packed {
        logic               rd_flag;  // word data goes out
        logic [BANK_W-1:0]  rot;      // bank of the first byte
        logic [COUNT_W-1:0] done;
        logic [1:0]         status;
        logic [LEVEL_W-1:0] used;
        logic [LEVEL_W-1:0] free;
    } brf_ctrl_t;

endpackage

`default_nettype wire

[design/byte_ring_fifo_core.sv]
// ---------------------------------------------------------------------------
// byte_ring_fifo_core
// Byte ring FIFO with one slot kept empty, eight byte banks side by side.
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  request  | in_valid / in_ready   | req_type, in_data, byte_count
//  result   | out_valid / out_ready | out_data, done_count, status,
//           |                       | used_bytes, free_bytes
//
//  One request per cycle while in_ready is high; a result is registered
//  in the bank stage and then in the output register.
//  The banks are single ported and each word touches at most one row per bank.
//  Reset clears both pointers and the fill level; store contents stay as is.
//  A stalled result holds the two stages and in_ready drops once both fill.
//  STORE_DEPTH must be a multiple of eight.
// ---------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_core #(
    parameter int STORE_DEPTH = 4096,
    parameter int LANES       = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      req_type,
    input  wire logic [brf_pkg::DATA_W-1:0]      in_data,
    input  wire logic [brf_pkg::COUNT_W-1:0]     byte_count,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [brf_pkg::DATA_W-1:0]      out_data,
    output logic      [brf_pkg::COUNT_W-1:0]     done_count,
    output logic      [1:0]                      status,
    output logic      [brf_pkg::LEVEL_W-1:0]     used_bytes,
    output logic      [brf_pkg::LEVEL_W-1:0]     free_bytes
);

    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam logic [PTR_W-1:0]            MAX_USED = PTR_W'(STORE_DEPTH - 1);
    localparam logic [brf_pkg::COUNT_W-1:0] LANE_CAP = brf_pkg::COUNT_W'(LANES);

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] used_reg, used_next;
    logic             s1_v_reg, s1_v_next;
    logic             o_v_reg, o_v_next;

    brf_pkg::brf_ctrl_t ctrl_reg, ctrl_next;

    logic [brf_pkg::DATA_W-1:0]  out_data_reg;
    logic [brf_pkg::COUNT_W-1:0] done_reg;
    logic [1:0]                  status_reg;
    logic [brf_pkg::LEVEL_W-1:0] used_out_reg;
    logic [brf_pkg::LEVEL_W-1:0] free_out_reg;

    logic                        in_acc;
    logic                        s1_adv;
    logic [brf_pkg::COUNT_W-1:0] n;
    logic [PTR_W-1:0]            n_ext;
    logic [PTR_W-1:0]            free_now;
    logic [PTR_W-1:0]            free_next;
    logic                        is_enq;
    logic                        is_read;
    logic                        is_pop;
    logic                        no_room;
    logic                        no_data;
    logic                        ok;
    logic [PTR_W-1:0]            base;
    logic [PTR_W:0]              adv_sum;
    logic [PTR_W-1:0]            adv_ptr;
    logic                        wr_en;
    logic                        rd_en;
    logic [31:0]                 used_wide;
    logic [31:0]                 free_wide;

    logic [brf_pkg::BANKS-1:0][7:0] bank_q;
    logic [brf_pkg::DATA_W-1:0]     merged;

    // Handshakes
    assign s1_adv   = s1_v_reg && (!o_v_reg || out_ready);
    assign in_ready = !s1_v_reg || s1_adv;
    assign in_acc   = in_valid && in_ready;

    // Request decode and room / data check
    assign n        = (byte_count > LANE_CAP) ? LANE_CAP : byte_count;
    assign n_ext    = PTR_W'(n);
    assign free_now = MAX_USED - used_reg;
    assign is_enq   = (req_type == brf_pkg::REQ_ENQ);
    assign is_read  = (req_type == brf_pkg::REQ_DEQ) || (req_type == brf_pkg::REQ_PEEK);
    assign is_pop   = (req_type == brf_pkg::REQ_DEQ) || (req_type == brf_pkg::REQ_DISC);
    assign no_room  = is_enq && (free_now < n_ext);
    assign no_data  = !is_enq && (used_reg < n_ext);
    assign ok       = !no_room && !no_data;
    assign wr_en    = in_acc && is_enq && ok;
    assign rd_en    = in_acc && is_read && ok;
    assign base     = is_enq ? wp_reg : rp_reg;

    // Pointer advance with wrap
    always_comb
    begin
        adv_sum = {1'b0, base} + {1'b0, n_ext};
        if (adv_sum >= (PTR_W + 1)'(STORE_DEPTH))
        begin
            adv_sum = adv_sum - (PTR_W + 1)'(STORE_DEPTH);
        end
        adv_ptr = adv_sum[PTR_W-1:0];
    end

    // Pointer and fill level update
    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        used_next = used_reg;
        if (in_acc && ok)
        begin
            if (is_enq)
            begin
                wp_next   = adv_ptr;
                used_next = used_reg + n_ext;
            end
            else if (is_pop)
            begin
                rp_next   = adv_ptr;
                used_next = used_reg - n_ext;
            end
        end
    end

    assign free_next = MAX_USED - used_next;
    assign used_wide = 32'(used_next);
    assign free_wide = 32'(free_next);

    // Control word for the bank stage
    always_comb
    begin
        ctrl_next         = ctrl_reg;
        if (in_acc)
        begin
            ctrl_next.rd_flag = is_read && ok;
            ctrl_next.rot     = rp_reg[brf_pkg::BANK_W-1:0];
            ctrl_next.done    = ok ? n : '0;
            ctrl_next.status  = no_room ? brf_pkg::ST_NO_ROOM :
                                no_data ? brf_pkg::ST_NO_DATA : brf_pkg::ST_OK;
            ctrl_next.used    = used_wide[brf_pkg::LEVEL_W-1:0];
            ctrl_next.free    = free_wide[brf_pkg::LEVEL_W-1:0];
        end
    end

    // Stage valid flags
    assign s1_v_next = in_acc || (s1_v_reg && !s1_adv);
    assign o_v_next  = s1_adv || (o_v_reg && !out_ready);

    // Byte banks
    for (genvar b = 0; b < brf_pkg::BANKS; b++)
    begin : g_lane
        brf_lane #(
            .STORE_DEPTH (STORE_DEPTH),
            .LANE_ID     (b)
        ) u_lane (
            .clk     (clk),
            .base    (base),
            .cnt     (n),
            .wr_en   (wr_en),
            .rd_en   (rd_en),
            .wdata   (in_data),
            .rd_byte (bank_q[b])
        );
    end

    // Merge bank bytes into the result word
    brf_merge u_merge (
        .bank_q (bank_q),
        .ctrl   (ctrl_reg),
        .word   (merged)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            used_reg <= '0;
            s1_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            used_reg <= used_next;
            s1_v_reg <= s1_v_next;
            o_v_reg  <= o_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ctrl_reg <= ctrl_next;
        if (s1_adv)
        begin
            out_data_reg <= merged;
            done_reg     <= ctrl_reg.done;
            status_reg   <= ctrl_reg.status;
            used_out_reg <= ctrl_reg.used;
            free_out_reg <= ctrl_reg.free;
        end
    end

    assign out_valid  = o_v_reg;
    assign out_data   = out_data_reg;
    assign done_count = done_reg;
    assign status     = status_reg;
    assign used_bytes = used_out_reg;
    assign free_bytes = free_out_reg;

    // Checks
    `include "byte_ring_fifo_core_assert.svh"

    `BRF_CHECK_SAME(a_refused_empty, out_valid && (status != brf_pkg::ST_OK), (done_count == '0) && (out_data == '0))
    `BRF_CHECK_NEXT(a_accept_fills_s1, in_valid && in_ready, s1_v_reg)
    `BRF_CHECK_NEXT(a_ptr_hold, !(in_valid && in_ready), $stable(wp_reg) && $stable(rp_reg))

endmodule

`default_nettype wire

[design/brf_lane.sv]
// ---------------------------------------------------------------------------
// brf_lane
// One byte bank of the ring store. Works out which byte of the word lands
// in this bank, its row, and writes or reads it with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module brf_lane #(
    parameter int STORE_DEPTH = 4096,
    parameter int LANE_ID     = 0
) (
    input  wire logic                           clk,
    input  wire logic [$clog2(STORE_DEPTH)-1:0] base,
    input  wire logic [brf_pkg::COUNT_W-1:0]    cnt,
    input  wire logic                           wr_en,
    input  wire logic                           rd_en,
    input  wire logic [brf_pkg::DATA_W-1:0]     wdata,
    output logic      [7:0]                     rd_byte
);

    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam int ROW_W = PTR_W - brf_pkg::BANK_W;
    localparam int ROWS  = STORE_DEPTH / brf_pkg::BANKS;

    logic [7:0]                 mem [ROWS];
    logic [brf_pkg::BANK_W-1:0] k;
    logic                       active;
    logic [PTR_W:0]             addr_sum;
    logic [PTR_W-1:0]           addr;
    logic [ROW_W-1:0]           row;
    logic [7:0]                 wbyte;
    logic [7:0]                 rd_byte_reg;

    // Offset of this bank's byte within the word
    assign k      = brf_pkg::BANK_W'(LANE_ID) - base[brf_pkg::BANK_W-1:0];
    assign active = ({1'b0, k} < cnt);

    // Ring address with wrap
    always_comb
    begin
        addr_sum = {1'b0, base} + (PTR_W + 1)'(k);
        if (addr_sum >= (PTR_W + 1)'(STORE_DEPTH))
        begin
            addr_sum = addr_sum - (PTR_W + 1)'(STORE_DEPTH);
        end
        addr = addr_sum[PTR_W-1:0];
    end

    assign row   = addr[PTR_W-1:brf_pkg::BANK_W];
    assign wbyte = wdata[8*k +: 8];

    // Bank storage
    always_ff @(posedge clk)
    begin
        if (wr_en && active)
        begin
            mem[row] <= wbyte;
        end
        if (rd_en && active)
        begin
            rd_byte_reg <= mem[row];
        end
    end

    assign rd_byte = rd_byte_reg;

endmodule

`default_nettype wire

[design/brf_merge.sv]
// ---------------------------------------------------------------------------
// brf_merge
// Rotates the bank outputs back into word order and clears bytes past the
// count or of requests that return no data.
// ---------------------------------------------------------------------------
`default_nettype none

module brf_merge (
    input  wire logic [brf_pkg::BANKS-1:0][7:0] bank_q,
    input  wire brf_pkg::brf_ctrl_t             ctrl,
    output logic      [brf_pkg::DATA_W-1:0]     word
);

    // Byte i of the word came from bank (rot + i)
    always_comb
    begin
        logic [brf_pkg::BANK_W-1:0] idx;
        for (int i = 0; i < brf_pkg::BANKS; i++)
        begin
            idx = brf_pkg::BANK_W'(i) + ctrl.rot;
            if (ctrl.rd_flag && (brf_pkg::COUNT_W'(i) < ctrl.done))
            begin
                word[8*i +: 8] = bank_q[idx];
            end
            else
            begin
                word[8*i +: 8] = 8'd0;
            end
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for byte_ring_fifo_core. A queue of requests feeds a
// bursty driver; every accepted word runs through a behavioral ring model
// that predicts the reply. A monitor with its own stall pattern compares
// each reply word field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int DEPTH    = 4096;
    localparam int LANE_CNT = 8;
    localparam int DRAIN_CYCLES = 20;

    localparam int DATA_W  = brf_pkg::DATA_W;
    localparam int COUNT_W = brf_pkg::COUNT_W;
    localparam int LEVEL_W = brf_pkg::LEVEL_W;

    typedef struct packed {
        logic [1:0]         kind;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
    } fifo_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] done;
        logic [1:0]         status;
        logic [LEVEL_W-1:0] used;
        logic [LEVEL_W-1:0] free;
    } fifo_reply_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [1:0]          req_type   = brf_pkg::REQ_ENQ;
    logic [DATA_W-1:0]   in_data    = '0;
    logic [COUNT_W-1:0]  byte_count = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [DATA_W-1:0]   out_data;
    logic [COUNT_W-1:0]  done_count;
    logic [1:0]          status;
    logic [LEVEL_W-1:0]  used_bytes;
    logic [LEVEL_W-1:0]  free_bytes;

    // Model state: byte ring plus both pointers
    logic [7:0]          ring_mem [0:DEPTH-1];
    logic [LEVEL_W-1:0]  rd_ptr = '0;
    logic [LEVEL_W-1:0]  wr_ptr = '0;

    fifo_req_t   pending_reqs[$];
    fifo_reply_t predicted_replies[$];
    int          errors = 0;

    byte_ring_fifo_core #(
        .STORE_DEPTH (DEPTH),
        .LANES       (LANE_CNT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .in_data    (in_data),
        .byte_count (byte_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .done_count (done_count),
        .status     (status),
        .used_bytes (used_bytes),
        .free_bytes (free_bytes)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one request to the ring model and return the reply it earns
    function automatic fifo_reply_t serve_request(fifo_req_t rq);
        fifo_reply_t        rep;
        logic [LEVEL_W-1:0] n;
        logic [LEVEL_W-1:0] level;
        level = wr_ptr - rd_ptr;
        n = (rq.count > LANE_CNT) ? LEVEL_W'(LANE_CNT) : LEVEL_W'(rq.count);
        rep = '0;
        rep.status = brf_pkg::ST_OK;
        if (rq.kind == brf_pkg::REQ_ENQ)
        begin
            if (LEVEL_W'(DEPTH - 1) - level < n)
                rep.status = brf_pkg::ST_NO_ROOM;
            else
            begin
                for (int i = 0; i < n; i++)
                    ring_mem[wr_ptr + LEVEL_W'(i)] = rq.data[8*i +: 8];
                wr_ptr = wr_ptr + n;
                rep.done = COUNT_W'(n);
            end
        end
        else if (level < n)
            rep.status = brf_pkg::ST_NO_DATA;
        else
        begin
            if (rq.kind != brf_pkg::REQ_DISC)
                for (int i = 0; i < n; i++)
                    rep.data[8*i +: 8] = ring_mem[rd_ptr + LEVEL_W'(i)];
            if (rq.kind != brf_pkg::REQ_PEEK)
                rd_ptr = rd_ptr + n;
            rep.done = COUNT_W'(n);
        end
        rep.used = wr_ptr - rd_ptr;
        rep.free = LEVEL_W'(DEPTH - 1) - rep.used;
        return rep;
    endfunction

    task automatic add_req(logic [1:0] kind, logic [DATA_W-1:0] data,
                           logic [COUNT_W-1:0] count);
        fifo_req_t rq;
        rq.kind  = kind;
        rq.data  = data;
        rq.count = count;
        pending_reqs.push_back(rq);
    endtask

    // Random words; enq_pct and peek_pct steer the fill level, the rest
    // splits between dequeue and discard
    task automatic add_random(int n, int enq_pct, int peek_pct);
        int                 roll;
        logic [1:0]         kind;
        logic [COUNT_W-1:0] count;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(99);
            if (roll < enq_pct)
                kind = brf_pkg::REQ_ENQ;
            else if (roll < enq_pct + peek_pct)
                kind = brf_pkg::REQ_PEEK;
            else if ($urandom_range(1) == 0)
                kind = brf_pkg::REQ_DEQ;
            else
                kind = brf_pkg::REQ_DISC;
            roll = $urandom_range(99);
            if (roll < 75)
                count = COUNT_W'(LANE_CNT);
            else if (roll < 95)
                count = COUNT_W'($urandom_range(LANE_CNT));
            else
                count = COUNT_W'($urandom_range(15, LANE_CNT + 1));
            add_req(kind, {$urandom, $urandom}, count);
        end
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] exp_v,
                               logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Driver: bursts of words with random gaps between them
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        fifo_req_t rq;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                rq.kind  = req_type;
                rq.data  = in_data;
                rq.count = byte_count;
                predicted_replies.push_back(serve_request(rq));
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                rq = pending_reqs.pop_front();
                req_type   <= rq.kind;
                in_data    <= rq.data;
                byte_count <= rq.count;
                in_valid   <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side: out_ready follows a stall mode that is redrawn at random
    int stall_tick = 0;
    int stall_mode = 0;

    always @(posedge clk)
    begin
        if (stall_tick % 200 == 0)
            stall_mode = $urandom_range(2);
        stall_tick++;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(99) >= 35);
            default: out_ready <= ((stall_tick % 7) >= 3);
        endcase
    end

    // Monitor: compare each reply word with the oldest prediction
    always @(posedge clk)
    begin
        fifo_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_replies.size() == 0)
            begin
                $error("reply word with no request outstanding");
                errors++;
            end
            else
            begin
                want = predicted_replies.pop_front();
                check_field("out_data", want.data, out_data);
                check_field("done_count", DATA_W'(want.done), DATA_W'(done_count));
                check_field("status", DATA_W'(want.status), DATA_W'(status));
                check_field("used_bytes", DATA_W'(want.used), DATA_W'(used_bytes));
                check_field("free_bytes", DATA_W'(want.free), DATA_W'(free_bytes));
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        // Empty ring: zero count and refused reads
        add_req(brf_pkg::REQ_ENQ,  64'h0, 4'd0);
        add_req(brf_pkg::REQ_DEQ,  64'h0, 4'd1);
        add_req(brf_pkg::REQ_PEEK, 64'h0, 4'd8);
        add_req(brf_pkg::REQ_DISC, 64'h0, 4'd1);
        add_req(brf_pkg::REQ_DEQ,  64'h0, 4'd0);
        // Full-width words, and counts above the lane limit
        add_req(brf_pkg::REQ_ENQ,  64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        add_req(brf_pkg::REQ_ENQ,  64'h0, 4'd8);
        add_req(brf_pkg::REQ_ENQ,  64'h0123_4567_89AB_CDEF, 4'd15);
        add_req(brf_pkg::REQ_PEEK, 64'h0, 4'd8);
        add_req(brf_pkg::REQ_DEQ,  64'h0, 4'd8);
        add_req(brf_pkg::REQ_PEEK, 64'h0, 4'd3);
        add_req(brf_pkg::REQ_DISC, 64'h0, 4'd15);
        add_req(brf_pkg::REQ_DEQ,  64'h0, 4'd9);
        add_req(brf_pkg::REQ_DEQ,  64'h0, 4'd1);
        // Partial words and short reads
        add_req(brf_pkg::REQ_ENQ,  64'hAAAA_AAAA_AAAA_AAAA, 4'd5);
        add_req(brf_pkg::REQ_ENQ,  64'h5555_5555_5555_5555, 4'd3);
        add_req(brf_pkg::REQ_PEEK, 64'h0, 4'd2);
        add_req(brf_pkg::REQ_DISC, 64'h0, 4'd1);
        add_req(brf_pkg::REQ_DEQ,  64'h0, 4'd7);
        add_req(brf_pkg::REQ_PEEK, 64'h0, 4'd0);
        add_req(brf_pkg::REQ_DISC, 64'h0, 4'd0);
        add_req(brf_pkg::REQ_DISC, 64'h0, 4'd1);
        // Fill to full, churn at full, drain to empty, then mixed traffic
        add_random(640, 95, 2);
        add_random(60, 50, 20);
        add_random(700, 5, 5);
        add_random(130, 50, 20);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || in_valid || predicted_replies.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
